// ----- rtl/core/b64e_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-character map for the base64
// stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int BYTE_W      = 8;
    localparam int CHAR_W      = 7;
    localparam int SEXTET_W    = 6;
    localparam int GROUP_W     = 3 * BYTE_W;
    localparam int CHAR_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [1:0] PHASE_EMPTY = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    localparam logic [1:0] PAD_NONE = 2'd0;
    localparam logic [1:0] PAD_ONE  = 2'd1;
    localparam logic [1:0] PAD_TWO  = 2'd2;

    localparam logic [CHAR_IDX_W-1:0] CHAR_LAST = 2'd3;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [1:0]         pad_count;
        logic               is_last;
    } group_entry_t;

    function automatic logic [CHAR_W-1:0] sextet_to_char(input logic [SEXTET_W-1:0] v);
        logic [CHAR_W-1:0] v7;
        v7 = {1'b0, v};
        if (v < 6'd26) begin
            return v7 + 7'd65;
        end else if (v < 6'd52) begin
            return v7 + 7'd71;
        end else if (v < 6'd62) begin
            return v7 - 7'd4;
        end else if (v == 6'd62) begin
            return 7'h2B;
        end else begin
            return 7'h2F;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/b64e_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// Accepts input bytes, holds the open group and hands complete or
// closing groups to the group queue.
// ----------------------------------------------------------------------------
module b64e_front (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,
    input  wire logic                   s_axis_tlast,
    output logic                        push_valid,
    output b64e_pkg::group_entry_t      push_entry,
    input  wire logic                   push_ready
);
    import b64e_pkg::*;

    logic [BYTE_W-1:0] first_reg, first_next;
    logic [BYTE_W-1:0] second_reg, second_next;
    logic [1:0]        phase_reg, phase_next;
    logic              accept;

    assign s_axis_tready = push_ready;
    assign accept        = s_axis_tvalid && push_ready;

    always_comb begin
        first_next  = first_reg;
        second_next = second_reg;
        phase_next  = phase_reg;
        push_valid  = 1'b0;
        push_entry  = '0;
        if (accept) begin
            case (phase_reg)
                PHASE_ONE: begin
                    if (s_axis_tlast) begin
                        push_valid = 1'b1;
                        push_entry = '{group: {first_reg, s_axis_tdata, 8'h00},
                                       pad_count: PAD_ONE, is_last: 1'b1};
                    end else begin
                        second_next = s_axis_tdata;
                        phase_next  = PHASE_TWO;
                    end
                end
                PHASE_TWO: begin
                    push_valid = 1'b1;
                    push_entry = '{group: {first_reg, second_reg, s_axis_tdata},
                                   pad_count: PAD_NONE, is_last: s_axis_tlast};
                end
                default: begin
                    if (s_axis_tlast) begin
                        push_valid = 1'b1;
                        push_entry = '{group: {s_axis_tdata, 16'h0000},
                                       pad_count: PAD_TWO, is_last: 1'b1};
                    end else begin
                        first_next = s_axis_tdata;
                        phase_next = PHASE_ONE;
                    end
                end
            endcase
            if (push_valid) begin
                first_next  = '0;
                second_next = '0;
                phase_next  = PHASE_EMPTY;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= '0;
            second_reg <= '0;
            phase_reg  <= PHASE_EMPTY;
        end else begin
            first_reg  <= first_next;
            second_reg <= second_next;
            phase_reg  <= phase_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("group phase out of range");
    a_group_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |=> (phase_reg == PHASE_EMPTY))
        else $error("open group not cleared after hand-off");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/b64e_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// Short group queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module b64e_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push_valid,
    input  wire b64e_pkg::group_entry_t push_entry,
    output logic                        push_ready,
    output logic                        head_valid,
    output b64e_pkg::group_entry_t      head_entry,
    input  wire logic                   pop
);
    import b64e_pkg::*;

    group_entry_t           slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end else begin
            return p + 1'b1;
        end
    endfunction

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue overfilled");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/b64e_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// Turns one queued group into four characters, one per cycle while the
// output is not stalled, through a registered output beat.
// ----------------------------------------------------------------------------
module b64e_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   head_valid,
    input  wire b64e_pkg::group_entry_t head_entry,
    output logic                        pop,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [7:0]                  m_axis_tdata,
    output logic                        m_axis_tlast
);
    import b64e_pkg::*;

    logic [CHAR_IDX_W-1:0] idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  out_load;
    logic                  advance;
    logic [SEXTET_W-1:0]   sextet;
    logic [2:0]            pad_sum;

    assign out_load = !valid_reg || m_axis_tready;
    assign advance  = head_valid && out_load;
    assign pop      = advance && (idx_reg == CHAR_LAST);
    assign pad_sum  = {1'b0, idx_reg} + {1'b0, head_entry.pad_count};

    always_comb begin
        case (idx_reg)
            2'd0:    sextet = head_entry.group[23:18];
            2'd1:    sextet = head_entry.group[17:12];
            2'd2:    sextet = head_entry.group[11:6];
            default: sextet = head_entry.group[5:0];
        endcase
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (out_load) begin
            valid_next = head_valid;
        end
        if (advance) begin
            idx_next  = idx_reg + 1'b1;
            char_next = (pad_sum > 3'd3) ? PAD_CHAR : sextet_to_char(sextet);
            last_next = head_entry.is_last && (idx_reg == CHAR_LAST);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, char_reg};
    assign m_axis_tlast  = last_reg;

`ifndef SYNTHESIS
    a_mid_group_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != '0) |-> head_valid)
        else $error("group in progress without queued entry");
    a_last_on_fourth: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (idx_reg != CHAR_LAST)) |=> !last_reg)
        else $error("last flag on a character other than the fourth");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/base64_stream_encoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
//
//   channel  | dir | tdata                         | tlast
//   s_axis   | in  | [7:0] data_byte               | last_byte
//   m_axis   | out | [6:0] out_char, [7] zero      | last_char
//
// one character leaves per cycle while m_axis is not stalled; a group of
// three bytes becomes four characters at the back end, which bounds the sustained input rate
// the front takes a byte per cycle while the two-entry group queue has room
// synchronous active-low reset empties the open group, the queue and the
// output register
// m_axis stalls hold the current character; s_axis stalls only when the
// queue is full
// ----------------------------------------------------------------------------
module base64_stream_encoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic            m_axis_tlast
);
    import b64e_pkg::*;

    logic         push_valid;
    group_entry_t push_entry;
    logic         push_ready;
    logic         head_valid;
    group_entry_t head_entry;
    logic         pop;

    b64e_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_entry    (push_entry),
        .push_ready    (push_ready)
    );

    b64e_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    b64e_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire
